[hdl/gcss_pkg.sv]
// glyph cache stats scanner: shared types, status codes and command tables
// no dependencies

package gcss_pkg;

    localparam int APB_ADDR_BITS = 3;
    localparam logic [0:0] REG_EXPECTED_VERSION = 1'b0;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_VER   = 2'd1;
    localparam logic [1:0] ST_CMD   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    // letter offsets from 'A'
    localparam logic [4:0] LTR_C = 5'd2;
    localparam logic [4:0] LTR_H = 5'd7;
    localparam logic [4:0] LTR_L = 5'd11;
    localparam logic [4:0] LTR_M = 5'd12;
    localparam logic [4:0] LTR_Q = 5'd16;
    localparam logic [4:0] LTR_S = 5'd18;
    localparam logic [4:0] LTR_T = 5'd19;
    localparam logic [4:0] LTR_V = 5'd21;
    localparam logic [4:0] LTR_Z = 5'd25;

    localparam logic [4:0] LETTER_MASK = 5'h1f;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  version;
        logic [31:0] glyph_count;
        logic [31:0] command_count;
        logic [31:0] byte_count;
    } out_item_t;

    function automatic logic letter_known(input logic [4:0] letter);
        logic k;
        unique case (letter)
            LTR_C, LTR_H, LTR_L, LTR_M, LTR_Q,
            LTR_S, LTR_T, LTR_V, LTR_Z: k = 1'b1;
            default:                    k = 1'b0;
        endcase
        return k;
    endfunction

    // operand bytes per unit of width
    function automatic logic [2:0] operand_mult(input logic [4:0] letter);
        logic [2:0] m;
        unique case (letter)
            LTR_C:                             m = 3'd6;
            LTR_Q, LTR_S:                      m = 3'd4;
            LTR_H, LTR_L, LTR_M, LTR_T, LTR_V: m = 3'd2;
            default:                           m = 3'd0;
        endcase
        return m;
    endfunction

endpackage

[hdl/glyph_cache_stats_scanner_core.sv]
// Scans a glyph cache file one byte per request and returns one summary per file: status,
// version, glyph count, command count and byte count. A byte is taken every cycle unless the
// input stalls; it is scanned while it sits in the input register, and its result, if any, is
// loaded into the result register when the byte is taken from the input register, so a result
// passes through the input register and then the result register.
// The input stalls only while the result register holds a result that is not taken.
// expected_version lies at APB address 0; counters are COUNTER_BITS wide, reported clipped.
// depends on gcss_pkg, gcss_scan, gcss_out

module glyph_cache_stats_scanner_core #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  gcss_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output gcss_pkg::out_item_t                   m_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [gcss_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic               in_valid_reg;
    gcss_pkg::in_item_t in_reg;
    logic [7:0]         exp_ver_reg;

    logic                take;
    logic                out_free;
    logic                res_valid;
    gcss_pkg::out_item_t res;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == gcss_pkg::REG_EXPECTED_VERSION) ? {24'd0, exp_ver_reg}
                                                                  : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_ver_reg <= 8'd0;
        end else if (psel && penable && pwrite && paddr[2] == gcss_pkg::REG_EXPECTED_VERSION) begin
            exp_ver_reg <= pwdata[7:0];
        end
    end

    // input register
    assign take    = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    gcss_scan #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_scan (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_take        (take),
        .item             (in_reg),
        .expected_version (exp_ver_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    gcss_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (take && res_valid),
        .res     (res),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[hdl/gcss_scan.sv]
// glyph cache stats scanner: layout state machine and counters, one byte per request
// depends on gcss_pkg

module gcss_scan #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_take,
    input  gcss_pkg::in_item_t  item,
    input  logic [7:0]          expected_version,
    output logic                res_valid,
    output gcss_pkg::out_item_t res
);

    localparam logic [3:0] PH_VERSION = 4'd0;
    localparam logic [3:0] PH_NAME    = 4'd1;
    localparam logic [3:0] PH_COUNT   = 4'd2;
    localparam logic [3:0] PH_CODE    = 4'd3;
    localparam logic [3:0] PH_NCMD    = 4'd4;
    localparam logic [3:0] PH_CMD     = 4'd5;
    localparam logic [3:0] PH_SKIP    = 4'd6;
    localparam logic [3:0] PH_DRAIN   = 4'd7;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    logic [3:0]              phase_reg, phase_next;
    logic [2:0]              idx_reg, idx_next;
    logic [31:0]             acc_reg, acc_next;
    logic [7:0]              ver_reg, ver_next;
    logic [31:0]             glyphs_reg, glyphs_next;
    logic [31:0]             glyphs_left_reg, glyphs_left_next;
    logic [15:0]             cmds_left_reg, cmds_left_next;
    logic [5:0]              skip_reg, skip_next;
    logic [COUNTER_BITS-1:0] cmds_seen_reg, cmds_seen_next;
    logic [COUNTER_BITS-1:0] bytes_seen_reg, bytes_seen_next;

    always_comb begin
        logic [7:0]  b;
        logic [4:0]  letter;
        logic [2:0]  width;
        logic        end_cmd;
        logic        end_glyph;
        logic        has_status;
        logic [1:0]  status;
        logic [63:0] cmds_wide;
        logic [63:0] bytes_wide;

        b          = item.data_byte;
        letter     = item.data_byte[4:0] & gcss_pkg::LETTER_MASK;
        width      = item.data_byte[7:5];
        end_cmd    = 1'b0;
        end_glyph  = 1'b0;
        has_status = 1'b0;
        status     = gcss_pkg::ST_OK;

        phase_next       = phase_reg;
        idx_next         = idx_reg;
        acc_next         = acc_reg;
        ver_next         = ver_reg;
        glyphs_next      = glyphs_reg;
        glyphs_left_next = glyphs_left_reg;
        cmds_left_next   = cmds_left_reg;
        skip_next        = skip_reg;
        cmds_seen_next   = cmds_seen_reg;
        bytes_seen_next  = bytes_seen_reg;
        res_valid        = 1'b0;

        if (phase_reg != PH_DRAIN) begin
            bytes_seen_next = (bytes_seen_reg == CNT_MAX) ? bytes_seen_reg
                                                          : bytes_seen_reg + 1'b1;
            unique case (phase_reg)
                PH_VERSION: begin
                    ver_next = b;
                    if (b != expected_version) begin
                        has_status = 1'b1;
                        status     = gcss_pkg::ST_VER;
                    end else begin
                        phase_next = PH_NAME;
                    end
                end
                PH_NAME: begin
                    if (b == 8'd0) begin
                        phase_next = PH_COUNT;
                        idx_next   = 3'd0;
                        acc_next   = 32'd0;
                    end
                end
                PH_COUNT: begin
                    acc_next = {acc_reg[23:0], b};
                    idx_next = idx_reg + 3'd1;
                    if (idx_next >= 3'd4) begin
                        glyphs_next      = acc_next;
                        glyphs_left_next = acc_next;
                        idx_next         = 3'd0;
                        if (acc_next == 32'd0) begin
                            has_status = 1'b1;
                            status     = gcss_pkg::ST_OK;
                        end else begin
                            phase_next = PH_CODE;
                        end
                    end
                end
                PH_CODE: begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_next >= 3'd4) begin
                        idx_next   = 3'd0;
                        acc_next   = 32'd0;
                        phase_next = PH_NCMD;
                    end
                end
                PH_NCMD: begin
                    acc_next = {16'd0, acc_reg[7:0], b};
                    idx_next = idx_reg + 3'd1;
                    if (idx_next >= 3'd2) begin
                        idx_next       = 3'd0;
                        cmds_left_next = acc_next[15:0];
                        if (acc_next[15:0] == 16'd0) begin
                            end_glyph = 1'b1;
                        end else begin
                            phase_next = PH_CMD;
                        end
                    end
                end
                PH_CMD: begin
                    if (!gcss_pkg::letter_known(letter)) begin
                        has_status = 1'b1;
                        status     = gcss_pkg::ST_CMD;
                    end else begin
                        cmds_seen_next = (cmds_seen_reg == CNT_MAX) ? cmds_seen_reg
                                                                    : cmds_seen_reg + 1'b1;
                        cmds_left_next = cmds_left_reg - 16'd1;
                        skip_next      = 6'(gcss_pkg::operand_mult(letter) * width);
                        if (skip_next != 6'd0) begin
                            phase_next = PH_SKIP;
                        end else begin
                            end_cmd = 1'b1;
                        end
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_reg - 6'd1;
                    if (skip_next == 6'd0) begin
                        end_cmd = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_VERSION;
                end
            endcase

            if (end_cmd) begin
                if (cmds_left_next == 16'd0) begin
                    end_glyph = 1'b1;
                end else begin
                    phase_next = PH_CMD;
                end
            end
            if (end_glyph) begin
                glyphs_left_next = glyphs_left_reg - 32'd1;
                if (glyphs_left_next == 32'd0) begin
                    has_status = 1'b1;
                    status     = gcss_pkg::ST_OK;
                end else begin
                    phase_next = PH_CODE;
                end
            end

            if (!has_status && item.stream_end) begin
                has_status = 1'b1;
                status     = gcss_pkg::ST_TRUNC;
            end
            res_valid = has_status;
        end

        // reported counts are clipped to 32 bits
        cmds_wide  = 64'(cmds_seen_next);
        bytes_wide = 64'(bytes_seen_next);

        res.status        = status;
        res.version       = ver_next;
        res.glyph_count   = glyphs_next;
        res.command_count = (|cmds_wide[63:32]) ? 32'hffff_ffff : cmds_wide[31:0];
        res.byte_count    = (|bytes_wide[63:32]) ? 32'hffff_ffff : bytes_wide[31:0];

        // new file after the last byte, otherwise ignore bytes until the end
        if (item.stream_end) begin
            phase_next       = PH_VERSION;
            idx_next         = 3'd0;
            acc_next         = 32'd0;
            ver_next         = 8'd0;
            glyphs_next      = 32'd0;
            glyphs_left_next = 32'd0;
            cmds_left_next   = 16'd0;
            skip_next        = 6'd0;
            cmds_seen_next   = '0;
            bytes_seen_next  = '0;
        end else if (has_status) begin
            phase_next = PH_DRAIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_VERSION;
            idx_reg         <= 3'd0;
            acc_reg         <= 32'd0;
            ver_reg         <= 8'd0;
            glyphs_reg      <= 32'd0;
            glyphs_left_reg <= 32'd0;
            cmds_left_reg   <= 16'd0;
            skip_reg        <= 6'd0;
            cmds_seen_reg   <= '0;
            bytes_seen_reg  <= '0;
        end else if (item_take) begin
            phase_reg       <= phase_next;
            idx_reg         <= idx_next;
            acc_reg         <= acc_next;
            ver_reg         <= ver_next;
            glyphs_reg      <= glyphs_next;
            glyphs_left_reg <= glyphs_left_next;
            cmds_left_reg   <= cmds_left_next;
            skip_reg        <= skip_next;
            cmds_seen_reg   <= cmds_seen_next;
            bytes_seen_reg  <= bytes_seen_next;
        end
    end

endmodule

[hdl/gcss_out.sv]
// glyph cache stats scanner: result register toward the m_ channel
// depends on gcss_pkg

module gcss_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  gcss_pkg::out_item_t res,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output gcss_pkg::out_item_t m_data
);

    logic                m_valid_reg;
    gcss_pkg::out_item_t m_data_reg;

    assign free    = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= res;
        end
    end

endmodule
